[hdl/tdrq_pkg.sv]
// Shared types, constants and helpers for the timeout-dropping request queue.
// No dependencies; used by tdrq_front, tdrq_back and the top level.
`default_nettype none

package tdrq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int TIME_W      = 32;
	localparam int CNT_W       = 32;
	localparam int CAP_W       = 7;
	localparam int NUM_CNT     = 5;

	// request opcodes
	localparam logic OP_ARRIVAL  = 1'b0;
	localparam logic OP_COMPLETE = 1'b1;

	// counter slots
	localparam int CNT_ARRIVALS  = 0;
	localparam int CNT_ADMITTED  = 1;
	localparam int CNT_REJECTED  = 2;
	localparam int CNT_SERVED    = 3;
	localparam int CNT_TIMED_OUT = 4;

	// configuration register indexes
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic REG_TIMEOUT  = 1'b1;

	localparam logic [CAP_W-1:0]  CAPACITY_RST = CAP_W'(50);
	localparam logic [TIME_W-1:0] TIMEOUT_RST  = TIME_W'(1200000);

	typedef enum logic [1:0] {
		OUT_STARTED  = 2'd0,
		OUT_QUEUED   = 2'd1,
		OUT_REJECTED = 2'd2,
		OUT_NONE     = 2'd3
	} outcome_t;

	typedef struct packed {
		logic              opcode;
		logic [TIME_W-1:0] event_time;
	} req_t;

	typedef struct packed {
		outcome_t          arrival_outcome;
		logic              started_next;
		logic [TIME_W-1:0] wait_time;
		logic [6:0]        dropped_now;
		logic              busy_res;
		logic [6:0]        queue_length;
		logic [CNT_W-1:0]  total_arrivals;
		logic [CNT_W-1:0]  total_admitted;
		logic [CNT_W-1:0]  total_rejected;
		logic [CNT_W-1:0]  total_served;
		logic [CNT_W-1:0]  total_timed_out;
	} rsp_t;

	// classified request, front to back
	typedef struct packed {
		logic              is_arrival;
		logic [TIME_W-1:0] event_time;
	} cmd_t;

	typedef struct packed {
		logic [CAP_W-1:0]  capacity;
		logic [TIME_W-1:0] timeout;
	} cfg_t;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [6:0] sat7(input logic [FILL_W-1:0] v);
		return (32'(v) > 32'd127) ? 7'd127 : 7'(v);
	endfunction

endpackage

`default_nettype wire

[hdl/tdrq_front.sv]
// Front end: accepts requests, classifies them, holds them in a two-entry queue.
// Depends on tdrq_pkg.
`default_nettype none

module tdrq_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tdrq_pkg::req_t req,
	input  wire logic           req_valid,
	output logic                req_stall,
	output tdrq_pkg::cmd_t      cmd,
	output logic                cmd_valid,
	input  wire logic           cmd_pop
);

	tdrq_pkg::cmd_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	tdrq_pkg::cmd_t cmd_in;

	assign req_stall = (count_q == 2'd2);
	assign push      = req_valid && !req_stall;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];

	always_comb begin
		cmd_in.is_arrival = (req.opcode == tdrq_pkg::OP_ARRIVAL);
		cmd_in.event_time = req.event_time;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, cmd_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/tdrq_back.sv]
// Back end: server state, timestamp FIFO memory, timeout drain, counters, result register.
// Depends on tdrq_pkg.
`default_nettype none

module tdrq_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tdrq_pkg::cfg_t cfg,
	input  wire tdrq_pkg::cmd_t cmd,
	input  wire logic           cmd_valid,
	output logic                cmd_pop,
	output tdrq_pkg::rsp_t      rsp,
	output logic                rsp_valid,
	input  wire logic           rsp_stall
);

	localparam int PTR_W  = tdrq_pkg::PTR_W;
	localparam int FILL_W = tdrq_pkg::FILL_W;
	localparam int TIME_W = tdrq_pkg::TIME_W;
	localparam int CNT_W  = tdrq_pkg::CNT_W;
	localparam int NCNT   = tdrq_pkg::NUM_CNT;

	typedef enum logic {ST_IDLE, ST_CHK} state_t;

	state_t             state_q, state_d;
	logic               busy_q, busy_d;
	logic [FILL_W-1:0]  fill_q, fill_d;
	logic [PTR_W-1:0]   head_q, head_d;
	logic [PTR_W-1:0]   tail_q, tail_d;
	logic [CNT_W-1:0]   cnt_q [NCNT];
	logic [CNT_W-1:0]   cnt_d [NCNT];
	logic [NCNT-1:0]    inc;
	logic [6:0]         drop_q, drop_d;
	logic [TIME_W-1:0]  now_q;
	logic [TIME_W-1:0]  rd_data_q;
	logic [TIME_W-1:0]  mem [tdrq_pkg::QUEUE_DEPTH];
	logic               rsp_valid_q;
	tdrq_pkg::rsp_t     rsp_q, rsp_d;

	logic               can_emit, take, step, load, wr_en, has_room, stale;
	logic [TIME_W-1:0]  wait_val;
	logic [TIME_W:0]    limit;

	assign can_emit = !rsp_valid_q || !rsp_stall;
	assign take     = (state_q == ST_IDLE) && cmd_valid && can_emit;
	assign step     = (state_q == ST_CHK) && can_emit;
	assign cmd_pop  = take;
	assign rsp      = rsp_q;
	assign rsp_valid = rsp_valid_q;

	assign has_room = (32'(fill_q) < 32'(cfg.capacity)) &&
	                  (32'(fill_q) < 32'(tdrq_pkg::QUEUE_DEPTH));

	// entry under test is rd_data_q = mem[head_q]
	assign limit    = {1'b0, rd_data_q} + {1'b0, cfg.timeout};
	assign stale    = {1'b0, now_q} > limit;
	assign wait_val = (now_q >= rd_data_q) ? now_q - rd_data_q : '0;

	always_comb begin
		state_d = state_q;
		busy_d  = busy_q;
		fill_d  = fill_q;
		head_d  = head_q;
		tail_d  = tail_q;
		drop_d  = drop_q;
		inc     = '0;
		wr_en   = 1'b0;
		load    = 1'b0;
		rsp_d.arrival_outcome = tdrq_pkg::OUT_NONE;
		rsp_d.started_next    = 1'b0;
		rsp_d.wait_time       = '0;
		rsp_d.dropped_now     = '0;

		if (take) begin
			if (cmd.is_arrival) begin
				inc[tdrq_pkg::CNT_ARRIVALS] = 1'b1;
				load = 1'b1;
				if (!busy_q) begin
					busy_d = 1'b1;
					rsp_d.arrival_outcome = tdrq_pkg::OUT_STARTED;
					inc[tdrq_pkg::CNT_ADMITTED] = 1'b1;
					inc[tdrq_pkg::CNT_SERVED]   = 1'b1;
				end else if (has_room) begin
					wr_en  = 1'b1;
					tail_d = tdrq_pkg::next_ptr(tail_q);
					fill_d = fill_q + FILL_W'(1);
					rsp_d.arrival_outcome = tdrq_pkg::OUT_QUEUED;
					inc[tdrq_pkg::CNT_ADMITTED] = 1'b1;
				end else begin
					rsp_d.arrival_outcome = tdrq_pkg::OUT_REJECTED;
					inc[tdrq_pkg::CNT_REJECTED] = 1'b1;
				end
			end else if (!busy_q) begin
				load = 1'b1;
			end else if (fill_q == '0) begin
				busy_d = 1'b0;
				load   = 1'b1;
			end else begin
				state_d = ST_CHK;
				drop_d  = '0;
			end
		end

		if (step) begin
			head_d = tdrq_pkg::next_ptr(head_q);
			fill_d = fill_q - FILL_W'(1);
			if (stale) begin
				inc[tdrq_pkg::CNT_TIMED_OUT] = 1'b1;
				drop_d = (drop_q == 7'd127) ? drop_q : drop_q + 7'd1;
				if (fill_q == FILL_W'(1)) begin
					busy_d  = 1'b0;
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end else begin
				inc[tdrq_pkg::CNT_SERVED] = 1'b1;
				rsp_d.started_next = 1'b1;
				rsp_d.wait_time    = wait_val;
				load    = 1'b1;
				state_d = ST_IDLE;
			end
			rsp_d.dropped_now = drop_d;
		end

		for (int i = 0; i < NCNT; i++) begin
			cnt_d[i] = (inc[i] && (cnt_q[i] != '1)) ? cnt_q[i] + CNT_W'(1) : cnt_q[i];
		end

		rsp_d.busy_res        = busy_d;
		rsp_d.queue_length    = tdrq_pkg::sat7(fill_d);
		rsp_d.total_arrivals  = cnt_d[tdrq_pkg::CNT_ARRIVALS];
		rsp_d.total_admitted  = cnt_d[tdrq_pkg::CNT_ADMITTED];
		rsp_d.total_rejected  = cnt_d[tdrq_pkg::CNT_REJECTED];
		rsp_d.total_served    = cnt_d[tdrq_pkg::CNT_SERVED];
		rsp_d.total_timed_out = cnt_d[tdrq_pkg::CNT_TIMED_OUT];
	end

	// timestamp store; read port tracks the next head so the head entry is always ready
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tail_q] <= cmd.event_time;
		end
		rd_data_q <= mem[head_d];
	end

	always_ff @(posedge clk) begin
		if (take) begin
			now_q <= cmd.event_time;
		end
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			busy_q      <= 1'b0;
			fill_q      <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			drop_q      <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < NCNT; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			busy_q  <= busy_d;
			fill_q  <= fill_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			drop_q  <= drop_d;
			cnt_q   <= cnt_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= 32'(tdrq_pkg::QUEUE_DEPTH))
		else $error("queue fill above depth");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (fill_q == '0))
		else $error("idle server with waiting entries");

	a_chk_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHK) |-> (busy_q && (fill_q != '0)))
		else $error("drain running with empty queue or idle server");

endmodule

`default_nettype wire

[hdl/timeout_dropping_request_queue.sv]
// Timeout-dropping request queue. Each request is an arrival or a service
// completion; every request yields exactly one result. Arrivals start at once
// on an idle server, are queued while there is room under queue_capacity
// (clamped to the 64-entry store), or are rejected. A completion pops queued
// timestamps in order, dropping any older than timeout_ticks (event_time >
// stamp + timeout, 33-bit compare), and starts the first fresh one with its
// waiting time; with nothing fresh left the server goes idle. Five saturating
// 32-bit counters ride along in every result.
// Timing: a request is registered in the front queue. Arrivals, and completions
// with nothing queued, are handled directly from idle, so arrivals stream at one
// per cycle while results are not stalled and no drain runs. A completion that pops
// enters the drain, which reads one timestamp per cycle while results are not stalled,
// dropping stale entries until one is served or none is left. No clearing pass is needed.
// Config: APB, byte address 0 = queue_capacity, 4 = timeout_ticks; write only
// while idle. Depends on tdrq_pkg, tdrq_front, tdrq_back.
`default_nettype none

module timeout_dropping_request_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	// request channel
	input  wire tdrq_pkg::req_t req,
	input  wire logic           req_valid,
	output logic                req_stall,
	// result channel
	output tdrq_pkg::rsp_t      rsp,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	// APB configuration
	input  wire logic           psel,
	input  wire logic           penable,
	input  wire logic           pwrite,
	input  wire logic [2:0]     paddr,
	input  wire logic [31:0]    pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	tdrq_pkg::cfg_t cfg_q;
	tdrq_pkg::cmd_t cmd;
	logic           cmd_valid;
	logic           cmd_pop;
	logic           reg_sel;
	logic           reg_wr;

	// word select; bit 2 picks the register
	assign reg_sel = paddr[2];
	assign reg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity <= tdrq_pkg::CAPACITY_RST;
			cfg_q.timeout  <= tdrq_pkg::TIMEOUT_RST;
		end else if (reg_wr) begin
			unique case (reg_sel)
				tdrq_pkg::REG_CAPACITY: cfg_q.capacity <= pwdata[tdrq_pkg::CAP_W-1:0];
				tdrq_pkg::REG_TIMEOUT:  cfg_q.timeout  <= pwdata;
				default:                cfg_q          <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			tdrq_pkg::REG_CAPACITY: prdata = 32'(cfg_q.capacity);
			tdrq_pkg::REG_TIMEOUT:  prdata = cfg_q.timeout;
			default:                prdata = '0;
		endcase
	end

	// front: classify and buffer requests
	tdrq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop)
	);

	// back: server, timestamp store, drain and result register
	tdrq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

endmodule

`default_nettype wire
